### rtl/core/row_cluster_legalizer_top_assert.svh
// Assertion macros for the row cluster legalizer checker.
// Expects aclk and aresetn in the scope where they are used.
`ifndef ROW_CLUSTER_LEGALIZER_TOP_ASSERT_SVH
`define ROW_CLUSTER_LEGALIZER_TOP_ASSERT_SVH

// same-cycle implication
`define RCL_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("row_cluster_legalizer: assertion failed");

// next-cycle implication
`define RCL_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("row_cluster_legalizer: assertion failed");

`endif

### rtl/core/rcl_pkg.sv
// Shared constants, types and state codes of the row cluster legalizer.
// No dependencies.
package rcl_pkg;

    localparam int MAX_CLUSTERS = 256;
    localparam int FRAC_BITS    = 4;

    localparam int CL_IDX_W = $clog2(MAX_CLUSTERS);
    localparam int CL_CNT_W = $clog2(MAX_CLUSTERS + 1);

    localparam int DX_W    = 24;
    localparam int CW_W    = 16;
    localparam int X_W     = 20;
    localparam int W_W     = 20;
    localparam int CELLS_W = 16;
    localparam int FIRST_W = 16;
    localparam int IDX_W   = 8;
    localparam int Q_W     = 48;
    localparam int SITE_W  = 8;
    localparam int SITES_W = 16;
    localparam int DEN_W   = CELLS_W + SITE_W + FRAC_BITS;
    localparam int XRAW_W  = Q_W + SITE_W;
    localparam int PROD_W  = CELLS_W + W_W;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 20;

    localparam logic [CFG_IDX_W-1:0] CFG_ROW_ORIGIN = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROW_SITES  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SITE_WIDTH = 2'd2;

    localparam logic [X_W-1:0]     X_MAX    = '1;
    localparam logic [FIRST_W-1:0] CELL_MAX = '1;

    typedef struct packed {
        logic [X_W-1:0]     x;
        logic [W_W-1:0]     width;
        logic [CELLS_W-1:0] cells;
        logic [Q_W-1:0]     q;
        logic [FIRST_W-1:0] first;
    } cluster_t;

    localparam int ENTRY_W = $bits(cluster_t);

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,
        S_REJ,
        S_PUSH,
        S_DEN,
        S_DIV,
        S_MUL,
        S_CLAMP,
        S_READ,
        S_CMP,
        S_MMUL,
        S_MADD,
        S_WRITE,
        S_FIN
    } state_t;

    typedef struct packed {
        logic latch_in;
        logic push;
        logic div_start;
        logic mul;
        logic clamp;
        logic merge_mul;
        logic merge_add;
        logic write_top;
        logic out_load;
        logic out_reject;
    } ctrl_cmd_t;

    typedef struct packed {
        logic reject;
        logic div_busy;
        logic k_zero;
        logic overlap;
        logic out_free;
    } ctrl_sts_t;

endpackage

### rtl/core/row_cluster_legalizer_top.sv
// Channel    | Ports                                   | Beat
// input      | s_valid s_ready s_desired_x s_cell_width | one cell
// result     | m_valid m_ready m_accepted m_top_*       | one result per cell
// config     | cfg_wr_en cfg_index cfg_wdata            | one register write
// One cell at a time. A rejected cell passes S_CHECK and S_REJ to the result register.
// A placed cell passes push, collapse, a compare with the cluster below and write-back;
// each merge repeats the collapse (no compare once merged into the bottom cluster), and
// each collapse waits on the 48-step bit-serial divider. Sync active-low reset clears
// control state; the cluster RAM is not cleared. A stalled result holds one finished cell.
// Top level: joins rcl_ctrl and rcl_datapath. Depends on rcl_pkg.
module row_cluster_legalizer_top (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_wr_en,
    input  logic [rcl_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [rcl_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [rcl_pkg::DX_W-1:0]       s_desired_x,
    input  logic [rcl_pkg::CW_W-1:0]       s_cell_width,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic                           m_accepted,
    output logic [rcl_pkg::IDX_W-1:0]      m_top_index,
    output logic [rcl_pkg::X_W-1:0]        m_top_x,
    output logic [rcl_pkg::W_W-1:0]        m_top_width,
    output logic [rcl_pkg::FIRST_W-1:0]    m_top_first_cell,
    output logic [rcl_pkg::X_W-1:0]        m_placed_x
);

    rcl_pkg::ctrl_cmd_t cmd;
    rcl_pkg::ctrl_sts_t sts;

    rcl_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    rcl_datapath u_dp (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_index        (cfg_index),
        .cfg_wdata        (cfg_wdata),
        .s_desired_x      (s_desired_x),
        .s_cell_width     (s_cell_width),
        .cmd              (cmd),
        .sts              (sts),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_accepted       (m_accepted),
        .m_top_index      (m_top_index),
        .m_top_x          (m_top_x),
        .m_top_width      (m_top_width),
        .m_top_first_cell (m_top_first_cell),
        .m_placed_x       (m_placed_x)
    );

endmodule

### rtl/core/rcl_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module rcl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### rtl/core/rcl_div.sv
// Restoring divider, one quotient bit per cycle, unsigned operands.
// Depends on rcl_pkg.
module rcl_div (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      start,
    input  logic [rcl_pkg::Q_W-1:0]   dividend,
    input  logic [rcl_pkg::DEN_W-1:0] divisor,
    output logic                      busy,
    output logic [rcl_pkg::Q_W-1:0]   quotient
);

    localparam int CNT_W = $clog2(rcl_pkg::Q_W + 1);

    logic [rcl_pkg::Q_W-1:0]   dvd_reg, dvd_next;
    logic [rcl_pkg::DEN_W-1:0] rem_reg, rem_next;
    logic [CNT_W-1:0]          cnt_reg, cnt_next;
    logic                      busy_reg, busy_next;
    logic [rcl_pkg::DEN_W:0]   rem_sh;

    always_comb begin
        rem_sh    = {rem_reg, dvd_reg[rcl_pkg::Q_W-1]};
        dvd_next  = dvd_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        if (start) begin
            dvd_next  = dividend;
            rem_next  = '0;
            cnt_next  = CNT_W'(rcl_pkg::Q_W);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (rem_sh >= {1'b0, divisor}) begin
                rem_next = rcl_pkg::DEN_W'(rem_sh - {1'b0, divisor});
                dvd_next = {dvd_reg[rcl_pkg::Q_W-2:0], 1'b1};
            end else begin
                rem_next = rem_sh[rcl_pkg::DEN_W-1:0];
                dvd_next = {dvd_reg[rcl_pkg::Q_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
    end

    assign busy     = busy_reg;
    assign quotient = dvd_reg;

endmodule

### rtl/core/rcl_datapath.sv
// Datapath: configuration, top cluster registers, cluster RAM, divider,
// clamp and merge arithmetic, result register. Depends on rcl_pkg, rcl_ram, rcl_div.
module rcl_datapath (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_wr_en,
    input  logic [rcl_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [rcl_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  logic [rcl_pkg::DX_W-1:0]       s_desired_x,
    input  logic [rcl_pkg::CW_W-1:0]       s_cell_width,
    input  rcl_pkg::ctrl_cmd_t             cmd,
    output rcl_pkg::ctrl_sts_t             sts,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic                           m_accepted,
    output logic [rcl_pkg::IDX_W-1:0]      m_top_index,
    output logic [rcl_pkg::X_W-1:0]        m_top_x,
    output logic [rcl_pkg::W_W-1:0]        m_top_width,
    output logic [rcl_pkg::FIRST_W-1:0]    m_top_first_cell,
    output logic [rcl_pkg::X_W-1:0]        m_placed_x
);

    localparam int SPAN_W = rcl_pkg::SITES_W + rcl_pkg::SITE_W;
    localparam int SUM_W  = SPAN_W + 1;

    logic [rcl_pkg::X_W-1:0]     origin_reg;
    logic [rcl_pkg::SITES_W-1:0] sites_reg;
    logic [rcl_pkg::SITE_W-1:0]  site_reg;
    logic [rcl_pkg::X_W-1:0]     row_end_reg;

    logic [rcl_pkg::DX_W-1:0]     dx_reg;
    logic [rcl_pkg::CW_W-1:0]     w_reg;
    rcl_pkg::cluster_t            top_reg;
    logic [rcl_pkg::CL_IDX_W-1:0] k_reg;
    logic [rcl_pkg::CL_CNT_W-1:0] count_reg;
    logic [rcl_pkg::FIRST_W-1:0]  cell_cnt_reg;
    logic [rcl_pkg::W_W-1:0]      used_reg;
    logic [rcl_pkg::DEN_W-1:0]    den_reg;
    logic                         neg_reg;
    logic [rcl_pkg::XRAW_W-1:0]   xraw_reg;
    logic [rcl_pkg::PROD_W-1:0]   prod_reg;

    logic                          m_valid_reg;
    logic                          acc_reg;
    logic [rcl_pkg::IDX_W-1:0]     idx_reg;
    logic [rcl_pkg::X_W-1:0]       ox_reg;
    logic [rcl_pkg::W_W-1:0]       ow_reg;
    logic [rcl_pkg::FIRST_W-1:0]   ofirst_reg;
    logic [rcl_pkg::X_W-1:0]       oplaced_reg;

    logic [rcl_pkg::SITE_W-1:0]   site_eff;
    logic [SPAN_W-1:0]            span;
    logic [SUM_W-1:0]             end_sum;
    logic [rcl_pkg::X_W-1:0]      row_end_next;
    logic [rcl_pkg::X_W-1:0]      cap;
    logic [rcl_pkg::Q_W-1:0]      q_mag;
    logic [rcl_pkg::Q_W-1:0]      quot;
    logic                         div_busy;
    logic [rcl_pkg::ENTRY_W-1:0]  ram_rdata;
    rcl_pkg::cluster_t            prev;
    logic [rcl_pkg::XRAW_W-1:0]   x1;
    logic [rcl_pkg::X_W-1:0]      x_clamped;

    assign site_eff     = (site_reg == '0) ? rcl_pkg::SITE_W'(1) : site_reg;
    assign span         = SPAN_W'(sites_reg) * SPAN_W'(site_eff);
    assign end_sum      = SUM_W'(origin_reg) + SUM_W'(span);
    assign row_end_next = (end_sum > SUM_W'(rcl_pkg::X_MAX)) ? rcl_pkg::X_MAX
                                                             : end_sum[rcl_pkg::X_W-1:0];
    assign cap          = row_end_reg - origin_reg;
    assign q_mag        = top_reg.q[rcl_pkg::Q_W-1] ? (~top_reg.q + rcl_pkg::Q_W'(1))
                                                    : top_reg.q;
    assign prev         = rcl_pkg::cluster_t'(ram_rdata);

    always_comb begin
        x1 = (xraw_reg < rcl_pkg::XRAW_W'(origin_reg)) ? rcl_pkg::XRAW_W'(origin_reg)
                                                        : xraw_reg;
        if (x1 + rcl_pkg::XRAW_W'(top_reg.width) > rcl_pkg::XRAW_W'(row_end_reg)) begin
            x_clamped = (top_reg.width > row_end_reg) ? '0 : (row_end_reg - top_reg.width);
        end else begin
            x_clamped = x1[rcl_pkg::X_W-1:0];
        end
    end

    assign sts.reject   = (count_reg == rcl_pkg::CL_CNT_W'(rcl_pkg::MAX_CLUSTERS))
                       || (cell_cnt_reg == rcl_pkg::CELL_MAX)
                       || ((rcl_pkg::W_W + 1)'(used_reg) + (rcl_pkg::W_W + 1)'(w_reg)
                           > (rcl_pkg::W_W + 1)'(cap));
    assign sts.div_busy = div_busy;
    assign sts.k_zero   = (k_reg == '0);
    assign sts.overlap  = ((rcl_pkg::X_W + 1)'(prev.x) + (rcl_pkg::X_W + 1)'(prev.width))
                        > (rcl_pkg::X_W + 1)'(top_reg.x);
    assign sts.out_free = !m_valid_reg || m_ready;

    rcl_ram #(
        .WIDTH (rcl_pkg::ENTRY_W),
        .DEPTH (rcl_pkg::MAX_CLUSTERS)
    ) u_ram (
        .aclk  (aclk),
        .we    (cmd.write_top),
        .waddr (k_reg),
        .wdata (top_reg),
        .raddr (k_reg - rcl_pkg::CL_IDX_W'(1)),
        .rdata (ram_rdata)
    );

    rcl_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .dividend (q_mag),
        .divisor  (den_reg),
        .busy     (div_busy),
        .quotient (quot)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            origin_reg   <= '0;
            sites_reg    <= '0;
            site_reg     <= rcl_pkg::SITE_W'(1);
            count_reg    <= '0;
            cell_cnt_reg <= '0;
            used_reg     <= '0;
            k_reg        <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                unique case (cfg_index)
                    rcl_pkg::CFG_ROW_ORIGIN: origin_reg <= cfg_wdata;
                    rcl_pkg::CFG_ROW_SITES:  sites_reg  <= cfg_wdata[rcl_pkg::SITES_W-1:0];
                    rcl_pkg::CFG_SITE_WIDTH: site_reg   <= cfg_wdata[rcl_pkg::SITE_W-1:0];
                    default: ;
                endcase
            end
            if (cmd.push) begin
                k_reg        <= count_reg[rcl_pkg::CL_IDX_W-1:0];
                count_reg    <= count_reg + rcl_pkg::CL_CNT_W'(1);
                cell_cnt_reg <= cell_cnt_reg + rcl_pkg::FIRST_W'(1);
                used_reg     <= used_reg + rcl_pkg::W_W'(w_reg);
            end else if (cmd.merge_add) begin
                k_reg     <= k_reg - rcl_pkg::CL_IDX_W'(1);
                count_reg <= count_reg - rcl_pkg::CL_CNT_W'(1);
            end
            if (cmd.out_load || cmd.out_reject) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        row_end_reg <= row_end_next;
        if (cmd.latch_in) begin
            dx_reg <= s_desired_x;
            w_reg  <= s_cell_width;
        end
        if (cmd.push) begin
            top_reg.x     <= '0;
            top_reg.width <= rcl_pkg::W_W'(w_reg);
            top_reg.cells <= rcl_pkg::CELLS_W'(1);
            top_reg.q     <= rcl_pkg::Q_W'(dx_reg);
            top_reg.first <= cell_cnt_reg;
        end else if (cmd.merge_add) begin
            top_reg.q     <= prev.q + top_reg.q
                           - (rcl_pkg::Q_W'(prod_reg) << rcl_pkg::FRAC_BITS);
            top_reg.cells <= prev.cells + top_reg.cells;
            top_reg.width <= prev.width + top_reg.width;
            top_reg.first <= prev.first;
        end else if (cmd.clamp) begin
            top_reg.x <= x_clamped;
        end
        if (cmd.div_start) begin
            den_reg <= (rcl_pkg::DEN_W'(top_reg.cells) * rcl_pkg::DEN_W'(site_eff))
                       << rcl_pkg::FRAC_BITS;
            neg_reg <= top_reg.q[rcl_pkg::Q_W-1];
        end
        if (cmd.mul) begin
            xraw_reg <= neg_reg ? '0
                                : rcl_pkg::XRAW_W'(quot) * rcl_pkg::XRAW_W'(site_eff);
        end
        if (cmd.merge_mul) begin
            prod_reg <= rcl_pkg::PROD_W'(top_reg.cells) * rcl_pkg::PROD_W'(prev.width);
        end
        if (cmd.out_load) begin
            acc_reg     <= 1'b1;
            idx_reg     <= rcl_pkg::IDX_W'(k_reg);
            ox_reg      <= top_reg.x;
            ow_reg      <= top_reg.width;
            ofirst_reg  <= top_reg.first;
            oplaced_reg <= top_reg.x + top_reg.width - rcl_pkg::X_W'(w_reg);
        end else if (cmd.out_reject) begin
            acc_reg     <= 1'b0;
            idx_reg     <= '0;
            ox_reg      <= '0;
            ow_reg      <= '0;
            ofirst_reg  <= '0;
            oplaced_reg <= '0;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_accepted       = acc_reg;
    assign m_top_index      = idx_reg;
    assign m_top_x          = ox_reg;
    assign m_top_width      = ow_reg;
    assign m_top_first_cell = ofirst_reg;
    assign m_placed_x       = oplaced_reg;

endmodule

### rtl/core/rcl_ctrl.sv
// Controller: sequences check, push, collapse and merge steps per cell.
// Depends on rcl_pkg.
module rcl_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  rcl_pkg::ctrl_sts_t sts,
    output rcl_pkg::ctrl_cmd_t cmd
);

    rcl_pkg::state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= rcl_pkg::S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        unique case (state_reg)
            rcl_pkg::S_IDLE: begin
                s_ready      = 1'b1;
                cmd.latch_in = s_valid;
                if (s_valid) begin
                    state_next = rcl_pkg::S_CHECK;
                end
            end
            rcl_pkg::S_CHECK: begin
                state_next = sts.reject ? rcl_pkg::S_REJ : rcl_pkg::S_PUSH;
            end
            rcl_pkg::S_REJ: begin
                if (sts.out_free) begin
                    cmd.out_reject = 1'b1;
                    state_next     = rcl_pkg::S_IDLE;
                end
            end
            rcl_pkg::S_PUSH: begin
                cmd.push   = 1'b1;
                state_next = rcl_pkg::S_DEN;
            end
            rcl_pkg::S_DEN: begin
                cmd.div_start = 1'b1;
                state_next    = rcl_pkg::S_DIV;
            end
            rcl_pkg::S_DIV: begin
                if (!sts.div_busy) begin
                    state_next = rcl_pkg::S_MUL;
                end
            end
            rcl_pkg::S_MUL: begin
                cmd.mul    = 1'b1;
                state_next = rcl_pkg::S_CLAMP;
            end
            rcl_pkg::S_CLAMP: begin
                cmd.clamp  = 1'b1;
                state_next = sts.k_zero ? rcl_pkg::S_WRITE : rcl_pkg::S_READ;
            end
            rcl_pkg::S_READ: begin
                state_next = rcl_pkg::S_CMP;
            end
            rcl_pkg::S_CMP: begin
                state_next = sts.overlap ? rcl_pkg::S_MMUL : rcl_pkg::S_WRITE;
            end
            rcl_pkg::S_MMUL: begin
                cmd.merge_mul = 1'b1;
                state_next    = rcl_pkg::S_MADD;
            end
            rcl_pkg::S_MADD: begin
                cmd.merge_add = 1'b1;
                state_next    = rcl_pkg::S_DEN;
            end
            rcl_pkg::S_WRITE: begin
                cmd.write_top = 1'b1;
                state_next    = rcl_pkg::S_FIN;
            end
            rcl_pkg::S_FIN: begin
                if (sts.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = rcl_pkg::S_IDLE;
                end
            end
            default: begin
                state_next = rcl_pkg::S_IDLE;
            end
        endcase
    end

endmodule

### rtl/core/rcl_checker.sv
// Port-level checks on the legalizer top, attached by bind.
// Depends on rcl_pkg and row_cluster_legalizer_top_assert.svh.
`include "row_cluster_legalizer_top_assert.svh"

module rcl_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           cfg_wr_en,
    input logic [rcl_pkg::CFG_IDX_W-1:0]  cfg_index,
    input logic [rcl_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input logic                           s_valid,
    input logic                           s_ready,
    input logic [rcl_pkg::DX_W-1:0]       s_desired_x,
    input logic [rcl_pkg::CW_W-1:0]       s_cell_width,
    input logic                           m_valid,
    input logic                           m_ready,
    input logic                           m_accepted,
    input logic [rcl_pkg::IDX_W-1:0]      m_top_index,
    input logic [rcl_pkg::X_W-1:0]        m_top_x,
    input logic [rcl_pkg::W_W-1:0]        m_top_width,
    input logic [rcl_pkg::FIRST_W-1:0]    m_top_first_cell,
    input logic [rcl_pkg::X_W-1:0]        m_placed_x
);

    `RCL_ASSERT_NEXT(a_res_hold, m_valid && !m_ready, m_valid && $stable(m_accepted) && $stable(m_top_index) && $stable(m_top_x) && $stable(m_top_width) && $stable(m_top_first_cell) && $stable(m_placed_x))
    `RCL_ASSERT_SAME(a_rej_zero, m_valid && !m_accepted, m_top_index == '0 && m_top_x == '0 && m_top_width == '0 && m_top_first_cell == '0 && m_placed_x == '0)
    `RCL_ASSERT_NEXT(a_one_cell, s_valid && s_ready, !s_ready)
    `RCL_ASSERT_SAME(a_in_row, m_valid && m_accepted, 21'(m_top_x) + 21'(m_top_width) <= 21'hFFFFF)

endmodule

bind row_cluster_legalizer_top rcl_checker u_rcl_checker (.*);
